/* rtl/core/adcat_pkg.sv */
// Package with shared types and constants of the ADC averaging and temperature converter.
package adcat_pkg;

    localparam int CountW  = 13;
    localparam int SlopeW  = 16;
    localparam int OffsetW = 24;
    localparam int SampleW = 16;
    localparam int TsumW   = 22;
    localparam int WholeW  = 8;
    localparam int AvgW    = 16;
    localparam int VsumW   = 21;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 24;

    localparam logic [CfgIdxW-1:0] CfgTempCount  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgTempSlope  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgTempOffset = 2'd2;

    localparam logic ChTemp   = 1'b0;
    localparam logic ChVideo  = 1'b1;
    localparam logic KindTemp  = 1'b0;
    localparam logic KindVideo = 1'b1;

    localparam int VideoAvgLen = 20;
    localparam int TempScale   = 100;
    localparam int TempShift   = 6;
    localparam int SlopeShift  = 10;

    localparam logic [CountW-1:0] CountReset = 13'd256;
    localparam logic [TsumW-1:0]  AccMax     = {TsumW{1'b1}};

    localparam int VcntW = $clog2(VideoAvgLen + 1);

    // Slope product and the offset-corrected value before the scale divide.
    localparam int ProdW = TsumW + SlopeW;
    localparam int DiffW = ProdW - SlopeShift + 2;

    // Video mean: sum / VideoAvgLen as a multiply by a rounded-up reciprocal.
    localparam int VdSh  = VsumW + $clog2(VideoAvgLen);
    localparam int VdMW  = VsumW + 1;
    localparam longint unsigned VdM =
        ((longint'(1) << VdSh) + longint'(VideoAvgLen) - 1) / longint'(VideoAvgLen);
    localparam int VProdW = VsumW + VdMW;

    // Temperature: values at or above SatLimit give 255; below it they fit TnW bits.
    localparam longint unsigned SatLimit = longint'(TempScale) * 256;
    localparam int TnW   = $clog2(TempScale * 256);
    localparam int TqSh  = TnW + $clog2(TempScale);
    localparam int TqMW  = TnW + 1;
    localparam longint unsigned TqM =
        ((longint'(1) << TqSh) + longint'(TempScale) - 1) / longint'(TempScale);
    localparam int TqW   = TnW + TqMW;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [TsumW-1:0] tsum;
        logic [VsumW-1:0] vsum;
    } t_stage1;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [TsumW-1:0] tsum;
        logic [ProdW-1:0] prod;
        logic [AvgW-1:0]  avg;
    } t_stage2;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [TsumW-1:0] tsum;
        logic [DiffW-1:0] diff;
        logic [AvgW-1:0]  avg;
    } t_stage3;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [TsumW-1:0] tsum;
        logic             neg;
        logic             over;
        logic [TqW-1:0]   qprod;
        logic [AvgW-1:0]  avg;
    } t_stage4;

endpackage

/* rtl/core/adcat_in_if.sv */
// Input channel interface carrying tagged ADC samples.
interface adcat_in_if;
    import adcat_pkg::*;

    logic               valid;
    logic               ready;
    logic               channel;
    logic [SampleW-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

/* rtl/core/adcat_out_if.sv */
// Output channel interface carrying temperature and video results.
interface adcat_out_if;
    import adcat_pkg::*;

    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [TsumW-1:0]  temperature_sum;
    logic [WholeW-1:0] temperature_whole;
    logic [AvgW-1:0]   video_average;

    modport source (output valid, output result_kind, output temperature_sum,
                    output temperature_whole, output video_average, input ready);
    modport sink (input valid, input result_kind, input temperature_sum,
                  input temperature_whole, input video_average, output ready);
endinterface

/* rtl/core/adcat_acc.sv */
// Running sums and countdowns for temperature and video samples.
module adcat_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    adcat_in_if.sink                      i_in,
    input  logic [adcat_pkg::CountW-1:0]  i_count,
    input  logic                          i_take,
    output adcat_pkg::t_stage1            o_s1
);
    import adcat_pkg::*;

    logic [CountW-1:0] r_cd;
    logic [TsumW-1:0]  r_acc;
    logic [VsumW-1:0]  r_vsum;
    logic [VcntW-1:0]  r_vcnt;
    t_stage1           r_s1;

    logic              accept;
    logic [TsumW:0]    n_acc;
    logic [VsumW-1:0]  n_vsum;
    logic [VcntW-1:0]  n_vcnt;
    logic              temp_emit;
    logic              video_emit;

    assign i_in.ready = !r_s1.valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    assign n_acc  = {1'b0, r_acc} + (TsumW + 1)'(i_in.sample >> TempShift);
    assign n_vsum = r_vsum + VsumW'(i_in.sample);
    assign n_vcnt = r_vcnt + VcntW'(1);

    assign temp_emit  = (i_in.channel == ChTemp) && (r_cd == '0);
    assign video_emit = (i_in.channel == ChVideo) && (n_vcnt >= VcntW'(VideoAvgLen));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd   <= CountReset;
            r_acc  <= '0;
            r_vsum <= '0;
            r_vcnt <= '0;
        end else if (accept) begin
            if (i_in.channel == ChTemp) begin
                if (temp_emit) begin
                    r_acc <= '0;
                    r_cd  <= i_count;
                end else begin
                    r_acc <= n_acc[TsumW] ? AccMax : n_acc[TsumW-1:0];
                    r_cd  <= r_cd - CountW'(1);
                end
            end else begin
                if (video_emit) begin
                    r_vsum <= '0;
                    r_vcnt <= '0;
                end else begin
                    r_vsum <= n_vsum;
                    r_vcnt <= n_vcnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            if (accept && (temp_emit || video_emit)) begin
                r_s1.valid <= 1'b1;
                r_s1.kind  <= temp_emit ? KindTemp : KindVideo;
                r_s1.tsum  <= temp_emit ? r_acc : '0;
                r_s1.vsum  <= video_emit ? n_vsum : '0;
            end else if (i_take) begin
                r_s1.valid <= 1'b0;
            end
        end
    end

    assign o_s1 = r_s1;
endmodule

/* rtl/core/adcat_conv.sv */
// Conversion pipeline from sums to temperature degrees and video means.
module adcat_conv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  adcat_pkg::t_stage1             i_s1,
    output logic                           o_take,
    input  logic [adcat_pkg::SlopeW-1:0]   i_slope,
    input  logic [adcat_pkg::OffsetW-1:0]  i_offset,
    adcat_out_if.source                    o_out
);
    import adcat_pkg::*;

    t_stage2           r_s2;
    t_stage3           r_s3;
    t_stage4           r_s4;
    logic              r_valid;
    logic              r_kind;
    logic [TsumW-1:0]  r_tsum;
    logic [WholeW-1:0] r_whole;
    logic [AvgW-1:0]   r_avg;

    logic              en2;
    logic              en3;
    logic              en4;
    logic              en_o;
    logic [ProdW-1:0]  n_prod;
    logic [VProdW-1:0] n_vprod;
    logic [DiffW-1:0]  n_diff;
    logic              n_neg;
    logic              n_over;
    logic [TqW-1:0]    n_qprod;
    logic [WholeW-1:0] n_whole;

    assign en_o   = !r_valid || o_out.ready;
    assign en4    = !r_s4.valid || en_o;
    assign en3    = !r_s3.valid || en4;
    assign en2    = !r_s2.valid || en3;
    assign o_take = en2;

    assign n_prod  = ProdW'(i_s1.tsum) * ProdW'(i_slope);
    assign n_vprod = VProdW'(i_s1.vsum) * VProdW'(VdM);

    assign n_diff = DiffW'(r_s2.prod[ProdW-1:SlopeShift])
                  - {{(DiffW - OffsetW){i_offset[OffsetW-1]}}, i_offset};

    assign n_neg   = r_s3.diff[DiffW-1];
    assign n_over  = !n_neg && (r_s3.diff >= DiffW'(SatLimit));
    assign n_qprod = TqW'(r_s3.diff[TnW-1:0]) * TqW'(TqM);

    always_comb begin
        if (r_s4.kind == KindVideo || r_s4.neg) begin
            n_whole = '0;
        end else if (r_s4.over) begin
            n_whole = {WholeW{1'b1}};
        end else begin
            n_whole = r_s4.qprod[TqSh+WholeW-1:TqSh];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (en2) begin
                r_s2.valid <= i_s1.valid;
                r_s2.kind  <= i_s1.kind;
                r_s2.tsum  <= i_s1.tsum;
                r_s2.prod  <= n_prod;
                r_s2.avg   <= n_vprod[VdSh+AvgW-1:VdSh];
            end
            if (en3) begin
                r_s3.valid <= r_s2.valid;
                r_s3.kind  <= r_s2.kind;
                r_s3.tsum  <= r_s2.tsum;
                r_s3.diff  <= n_diff;
                r_s3.avg   <= r_s2.avg;
            end
            if (en4) begin
                r_s4.valid <= r_s3.valid;
                r_s4.kind  <= r_s3.kind;
                r_s4.tsum  <= r_s3.tsum;
                r_s4.neg   <= n_neg;
                r_s4.over  <= n_over;
                r_s4.qprod <= n_qprod;
                r_s4.avg   <= r_s3.avg;
            end
            if (en_o) begin
                r_valid <= r_s4.valid;
                r_kind  <= r_s4.kind;
                r_tsum  <= r_s4.tsum;
                r_whole <= n_whole;
                r_avg   <= r_s4.avg;
            end
        end
    end

    assign o_out.valid             = r_valid;
    assign o_out.result_kind       = r_kind;
    assign o_out.temperature_sum   = r_tsum;
    assign o_out.temperature_whole = r_whole;
    assign o_out.video_average     = r_avg;
endmodule

/* rtl/core/adc_average_temperature_convert.sv */
// Top level of the ADC averaging and temperature converter.
// Samples enter on i_in as transactions tagged with a channel. Temperature
// samples are shifted right by six and summed while a countdown runs; the
// temperature sample that finds the countdown at zero is not summed but
// triggers a conversion of the sum to whole degrees, saturated to 0..255.
// Video samples are summed, and every twentieth one yields their mean.
// Each result leaves on o_out as one transaction; other samples give none.
// The configuration port writes the sample count, slope and offset with
// i_cfg_we, i_cfg_index and i_cfg_data; the user must see that it is written
// only while the block is idle, which the block itself does not enforce. A
// result reaches o_out through the multiply, offset, scale and output registers.
// One sample is accepted in every cycle while i_in.ready is high. When the
// receiver stalls, results wait in the pipeline registers and samples are
// still taken; i_in.ready drops only when all five result registers are
// full and o_out.ready is low. Reset restores the count to 256, slope and
// offset to zero, clears the sums and empties the pipeline.
module adc_average_temperature_convert (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    adcat_in_if.sink                        i_in,
    adcat_out_if.source                     o_out,
    input  logic                            i_cfg_we,
    input  logic [adcat_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [adcat_pkg::CfgDataW-1:0]  i_cfg_data
);
    import adcat_pkg::*;

    logic [CountW-1:0]  r_count;
    logic [SlopeW-1:0]  r_slope;
    logic [OffsetW-1:0] r_offset;
    t_stage1            s1;
    logic               take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CountReset;
            r_slope  <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgTempCount:  r_count  <= i_cfg_data[CountW-1:0];
                CfgTempSlope:  r_slope  <= i_cfg_data[SlopeW-1:0];
                CfgTempOffset: r_offset <= i_cfg_data[OffsetW-1:0];
                default: begin
                end
            endcase
        end
    end

    adcat_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_count (r_count),
        .i_take  (take),
        .o_s1    (s1)
    );

    adcat_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1     (s1),
        .o_take   (take),
        .i_slope  (r_slope),
        .i_offset (r_offset),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_video_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.result_kind == KindVideo
        |-> o_out.temperature_sum == '0 && o_out.temperature_whole == '0)
        else $error("video result carries temperature fields");

    a_temp_zero_video: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.result_kind == KindTemp |-> o_out.video_average == '0)
        else $error("temperature result carries a video average");

    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> s1.valid && !take)
        else $error("input stalled while the first stage can move");
`endif
endmodule
